### hdl/sst_pkg.sv
// Package for the sorted-list Tanimoto block: sizes, item kinds and the
// command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

  localparam int MAX_LEN   = 1024;
  localparam int FRAC_BITS = 16;

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int LEN_W  = ADDR_W + 1;
  localparam int UNI_W  = LEN_W + 1;
  localparam int WORD_W = 32;
  localparam int KIND_W = 2;
  localparam int SIM_W  = FRAC_BITS + 1;

  // dividend is common_count shifted up by the fraction bits
  localparam int DVD_W     = LEN_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  localparam logic [KIND_W-1:0] KIND_PUSH_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

  localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic push_a;
    logic push_b;
    logic walk_init;
    logic walk_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic div_done;
    logic out_full;
  } dp_status_t;

endpackage

### hdl/sst_if.sv
// Valid/ready channel interfaces for the input items and the results.
// Depends on sst_pkg for field widths.
`timescale 1ns / 1ps

interface sst_in_if;
  logic                         valid;
  logic                         ready;
  logic [sst_pkg::KIND_W-1:0]   kind;
  logic [sst_pkg::WORD_W-1:0]   word;

  modport source (output valid, output kind, output word, input ready);
  modport sink (input valid, input kind, input word, output ready);
endinterface

interface sst_out_if;
  logic                         valid;
  logic                         ready;
  logic [sst_pkg::SIM_W-1:0]    similarity;
  logic [sst_pkg::LEN_W-1:0]    common_count;
  logic [sst_pkg::UNI_W-1:0]    union_count;
  logic                         overflow;

  modport source (output valid, output similarity, output common_count,
                  output union_count, output overflow, input ready);
  modport sink (input valid, input similarity, input common_count,
                input union_count, input overflow, output ready);
endinterface

### hdl/sorted_set_tanimoto.sv
// Tanimoto similarity of two ascending word lists (top level).
// Throughput: one push per cycle while no finish is in progress. A finish blocks
// the input until its result is loaded: a merge walk of at most len_a + len_b - 1
// steps, then the bit-serial divider (27 quotient bits, one done check).
// The load also waits while the previous result is still unaccepted.
// Reset (sync, active low) empties both lists and clears overflow; no sweep.
`timescale 1ns / 1ps

module sorted_set_tanimoto (
  input  logic      clk,
  input  logic      rst_n,
  sst_in_if.sink    in_ch,
  sst_out_if.source out_ch
);

  sst_pkg::ctrl_cmd_t  cmd;
  sst_pkg::dp_status_t status;

  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sst_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_word          (in_ch.word),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_similarity   (out_ch.similarity),
    .out_common_count (out_ch.common_count),
    .out_union_count  (out_ch.union_count),
    .out_overflow     (out_ch.overflow)
  );

endmodule

### hdl/sst_dp.sv
// Datapath: list memories, lengths, merge-walk pointers, restoring divider
// and result register. Driven by sst_ctrl through sst_pkg::ctrl_cmd_t.
`timescale 1ns / 1ps

module sst_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sst_pkg::ctrl_cmd_t          cmd,
  output sst_pkg::dp_status_t         status,
  input  logic [sst_pkg::WORD_W-1:0]  in_word,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [sst_pkg::SIM_W-1:0]   out_similarity,
  output logic [sst_pkg::LEN_W-1:0]   out_common_count,
  output logic [sst_pkg::UNI_W-1:0]   out_union_count,
  output logic                        out_overflow
);

  logic [sst_pkg::WORD_W-1:0] mem_a [sst_pkg::MAX_LEN];
  logic [sst_pkg::WORD_W-1:0] mem_b [sst_pkg::MAX_LEN];
  logic [sst_pkg::WORD_W-1:0] rd_a_r, rd_b_r;

  logic [sst_pkg::LEN_W-1:0] len_a_r, len_b_r;
  logic [sst_pkg::LEN_W-1:0] i_r, j_r, common_r;
  logic                      dropped_r;

  logic [sst_pkg::UNI_W-1:0]     uni_r;
  logic [sst_pkg::UNI_W-1:0]     rem_r;
  logic [sst_pkg::DVD_W-1:0]     dvd_r;
  logic [sst_pkg::SIM_W-1:0]     quo_r;
  logic [sst_pkg::DIV_CNT_W-1:0] div_cnt_r;

  logic                      out_valid_r;
  logic [sst_pkg::SIM_W-1:0] sim_r;
  logic [sst_pkg::LEN_W-1:0] res_common_r;
  logic [sst_pkg::UNI_W-1:0] res_uni_r;
  logic                      res_ovf_r;

  logic full_a, full_b;
  logic [sst_pkg::UNI_W-1:0] rem_sh;
  logic [sst_pkg::UNI_W-1:0] rem_nxt;
  logic                      rem_ge;

  assign full_a = (len_a_r == sst_pkg::LEN_W'(sst_pkg::MAX_LEN));
  assign full_b = (len_b_r == sst_pkg::LEN_W'(sst_pkg::MAX_LEN));

  // list memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.push_a && !full_a) begin
      mem_a[len_a_r[sst_pkg::ADDR_W-1:0]] <= in_word;
    end
    rd_a_r <= mem_a[i_r[sst_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.push_b && !full_b) begin
      mem_b[len_b_r[sst_pkg::ADDR_W-1:0]] <= in_word;
    end
    rd_b_r <= mem_b[j_r[sst_pkg::ADDR_W-1:0]];
  end

  // lengths and dropped flag; cleared when the result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r   <= '0;
      len_b_r   <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.load_out) begin
      len_a_r   <= '0;
      len_b_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      if (cmd.push_a) begin
        if (full_a) dropped_r <= 1'b1;
        else        len_a_r   <= len_a_r + sst_pkg::LEN_W'(1);
      end
      if (cmd.push_b) begin
        if (full_b) dropped_r <= 1'b1;
        else        len_b_r   <= len_b_r + sst_pkg::LEN_W'(1);
      end
    end
  end

  // merge walk
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      i_r      <= '0;
      j_r      <= '0;
      common_r <= '0;
    end else if (cmd.walk_step) begin
      if (rd_a_r == rd_b_r) begin
        common_r <= common_r + sst_pkg::LEN_W'(1);
        i_r      <= i_r + sst_pkg::LEN_W'(1);
        j_r      <= j_r + sst_pkg::LEN_W'(1);
      end else if (rd_a_r < rd_b_r) begin
        i_r <= i_r + sst_pkg::LEN_W'(1);
      end else begin
        j_r <= j_r + sst_pkg::LEN_W'(1);
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem_r[sst_pkg::UNI_W-2:0], dvd_r[sst_pkg::DVD_W-1]};
  assign rem_ge  = (rem_sh >= uni_r);
  assign rem_nxt = rem_ge ? (rem_sh - uni_r) : rem_sh;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      uni_r     <= sst_pkg::UNI_W'(len_a_r) + sst_pkg::UNI_W'(len_b_r)
                   - sst_pkg::UNI_W'(common_r);
      rem_r     <= '0;
      dvd_r     <= {common_r, {sst_pkg::FRAC_BITS{1'b0}}};
      quo_r     <= '0;
      div_cnt_r <= sst_pkg::DIV_CNT_W'(sst_pkg::DVD_W);
    end else if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      dvd_r     <= {dvd_r[sst_pkg::DVD_W-2:0], 1'b0};
      quo_r     <= {quo_r[sst_pkg::SIM_W-2:0], rem_ge};
      div_cnt_r <= div_cnt_r - sst_pkg::DIV_CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sim_r        <= (uni_r == '0) ? sst_pkg::SIM_ONE : quo_r;
      res_common_r <= common_r;
      res_uni_r    <= uni_r;
      res_ovf_r    <= dropped_r;
    end
  end

  assign status.walk_done = (i_r >= len_a_r) || (j_r >= len_b_r);
  assign status.div_done  = (div_cnt_r == '0);
  assign status.out_full  = out_valid_r;

  assign out_valid        = out_valid_r;
  assign out_similarity   = sim_r;
  assign out_common_count = res_common_r;
  assign out_union_count  = res_uni_r;
  assign out_overflow     = res_ovf_r;

endmodule

### hdl/sst_ctrl.sv
// Controller state machine: takes input transactions, sequences the merge
// walk, the division and the result load. Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [sst_pkg::KIND_W-1:0]  in_kind,
  output logic                        in_ready,
  input  sst_pkg::dp_status_t         status,
  output sst_pkg::ctrl_cmd_t          cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_WALK_RD = 3'd1;
  localparam logic [2:0] S_WALK_CMP = 3'd2;
  localparam logic [2:0] S_DIV     = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       take;

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.push_a = take && (in_kind == sst_pkg::KIND_PUSH_A);
        cmd.push_b = take && (in_kind == sst_pkg::KIND_PUSH_B);
        if (take && (in_kind == sst_pkg::KIND_FINISH)) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK_RD;
        end
      end
      // read data for the current pointers lands at the end of this cycle
      S_WALK_RD: begin
        if (status.walk_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_WALK_CMP;
        end
      end
      S_WALK_CMP: begin
        cmd.walk_step = 1'b1;
        state_nxt     = S_WALK_RD;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sim/sorted_set_tanimoto_tb.sv
// Self-checking bench for sorted_set_tanimoto: directed rows, a list filled past
// capacity and random list pairs, scored against a Tanimoto predictor in the bench.
// Depends on sst_pkg, the sst_in_if/sst_out_if interfaces and the block itself.
`timescale 1ns / 1ps

module sorted_set_tanimoto_tb;

  localparam logic [sst_pkg::KIND_W-1:0] KIND_NONE = 2'd3;  // undefined kind, block ignores it
  localparam int RANDOM_ITEMS = 560;
  localparam int PHASE_ITEMS  = 140;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 600;

  typedef struct packed {
    logic [sst_pkg::SIM_W-1:0] similarity;
    logic [sst_pkg::LEN_W-1:0] common_count;
    logic [sst_pkg::UNI_W-1:0] union_count;
    logic                      overflow;
  } score_t;

  typedef struct packed {
    logic [sst_pkg::KIND_W-1:0] kind;
    logic [sst_pkg::WORD_W-1:0] word;
    logic                       pinned;
    score_t                     score;
  } stim_row_t;

  localparam score_t NO_SCORE = '0;

  localparam stim_row_t DIR_TAB [23] = '{
    '{sst_pkg::KIND_FINISH, 32'h0,        1'b1, '{sst_pkg::SIM_ONE, 11'd0, 12'd0, 1'b0}},
    '{sst_pkg::KIND_PUSH_A, 32'h0,        1'b0, NO_SCORE},
    '{sst_pkg::KIND_PUSH_B, 32'h0,        1'b0, NO_SCORE},
    '{sst_pkg::KIND_FINISH, 32'h0,        1'b1, '{sst_pkg::SIM_ONE, 11'd1, 12'd1, 1'b0}},
    '{sst_pkg::KIND_PUSH_A, 32'h0,        1'b0, NO_SCORE},
    '{sst_pkg::KIND_PUSH_A, 32'hFFFFFFFF, 1'b0, NO_SCORE},
    '{sst_pkg::KIND_PUSH_B, 32'hFFFFFFFF, 1'b0, NO_SCORE},
    '{sst_pkg::KIND_FINISH, 32'hFFFFFFFF, 1'b1, '{17'd32768, 11'd1, 12'd2, 1'b0}},
    '{sst_pkg::KIND_PUSH_A, 32'h7,        1'b0, NO_SCORE},
    '{sst_pkg::KIND_FINISH, 32'h0,        1'b1, '{17'd0,     11'd0, 12'd1, 1'b0}},
    '{sst_pkg::KIND_PUSH_B, 32'h1,        1'b0, NO_SCORE},
    '{sst_pkg::KIND_PUSH_B, 32'h2,        1'b0, NO_SCORE},
    '{sst_pkg::KIND_PUSH_B, 32'h3,        1'b0, NO_SCORE},
    '{sst_pkg::KIND_PUSH_A, 32'h2,        1'b0, NO_SCORE},
    '{KIND_NONE,            32'hFFFFFFFF, 1'b0, NO_SCORE},
    '{sst_pkg::KIND_FINISH, 32'h0,        1'b1, '{17'd21845, 11'd1, 12'd3, 1'b0}},
    // descending list A: walk stops early
    '{sst_pkg::KIND_PUSH_A, 32'h5,        1'b0, NO_SCORE},
    '{sst_pkg::KIND_PUSH_A, 32'h3,        1'b0, NO_SCORE},
    '{sst_pkg::KIND_PUSH_B, 32'h3,        1'b0, NO_SCORE},
    '{sst_pkg::KIND_FINISH, 32'h0,        1'b0, NO_SCORE},
    '{sst_pkg::KIND_PUSH_A, 32'hAAAAAAAA, 1'b0, NO_SCORE},
    '{sst_pkg::KIND_PUSH_B, 32'h55555555, 1'b0, NO_SCORE},
    '{sst_pkg::KIND_FINISH, 32'h0,        1'b1, '{17'd0,     11'd0, 12'd2, 1'b0}}
  };

  logic clk;
  logic rst_n;

  sst_in_if  in_ch();
  sst_out_if out_ch();

  sorted_set_tanimoto u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // pinned expectation travels with the transaction
  logic   drv_pin;
  score_t drv_pin_score;

  // predictor state
  logic [sst_pkg::WORD_W-1:0] fp_list_a [sst_pkg::MAX_LEN];
  logic [sst_pkg::WORD_W-1:0] fp_list_b [sst_pkg::MAX_LEN];
  int                         fp_len_a;
  int                         fp_len_b;
  logic                       fp_dropped;

  score_t pending_scores[$];
  int     mismatches;
  int     sent_items;
  int     idle_pct;
  int     stall_pct;
  int     hold_left;
  int     cycles;

  always #5 clk = ~clk;

  function automatic score_t tanimoto_of_lists();
    score_t            s;
    int                i;
    int                j;
    longint unsigned   common;
    longint unsigned   uni;
    i = 0;
    j = 0;
    common = 0;
    while (i < fp_len_a && j < fp_len_b) begin
      if (fp_list_a[i] == fp_list_b[j]) begin
        common++;
        i++;
        j++;
      end else if (fp_list_a[i] < fp_list_b[j]) begin
        i++;
      end else begin
        j++;
      end
    end
    uni = longint'(fp_len_a) + longint'(fp_len_b) - common;
    if (uni == 0) s.similarity = sst_pkg::SIM_ONE;
    else s.similarity = sst_pkg::SIM_W'((common << sst_pkg::FRAC_BITS) / uni);
    s.common_count = sst_pkg::LEN_W'(common);
    s.union_count  = sst_pkg::UNI_W'(uni);
    s.overflow     = fp_dropped;
    return s;
  endfunction

  // predictor: update on every accepted input transaction
  always @(posedge clk) begin : absorb_input
    score_t s;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      case (in_ch.kind)
        sst_pkg::KIND_PUSH_A: begin
          if (fp_len_a < sst_pkg::MAX_LEN) begin
            fp_list_a[fp_len_a] = in_ch.word;
            fp_len_a++;
          end else begin
            fp_dropped = 1'b1;
          end
        end
        sst_pkg::KIND_PUSH_B: begin
          if (fp_len_b < sst_pkg::MAX_LEN) begin
            fp_list_b[fp_len_b] = in_ch.word;
            fp_len_b++;
          end else begin
            fp_dropped = 1'b1;
          end
        end
        sst_pkg::KIND_FINISH: begin
          s = tanimoto_of_lists();
          pending_scores = {pending_scores, (drv_pin ? drv_pin_score : s)};
          fp_len_a   = 0;
          fp_len_b   = 0;
          fp_dropped = 1'b0;
        end
        default: ;
      endcase
    end
  end

  task automatic check_score(input score_t want, input score_t got);
    if (got.similarity !== want.similarity) begin
      $error("similarity: expected %0d, got %0d", want.similarity, got.similarity);
      mismatches++;
    end
    if (got.common_count !== want.common_count) begin
      $error("common_count: expected %0d, got %0d", want.common_count, got.common_count);
      mismatches++;
    end
    if (got.union_count !== want.union_count) begin
      $error("union_count: expected %0d, got %0d", want.union_count, got.union_count);
      mismatches++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : score_check
    score_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.similarity, out_ch.common_count, out_ch.union_count, out_ch.overflow};
      if (pending_scores.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
      end else begin
        check_score(pending_scores.pop_front(), got);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("sorted_set_tanimoto_tb NOT OK");
      $finish;
    end
  end

  task automatic send_item(input logic [sst_pkg::KIND_W-1:0] k,
                           input logic [sst_pkg::WORD_W-1:0] w,
                           input logic pin, input score_t sc);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.word    <= w;
    drv_pin       <= pin;
    drv_pin_score <= sc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (k != KIND_NONE) sent_items++;
  endtask

  task automatic set_phase(input int p);
    case (p)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 73; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 73; end
      default: begin idle_pct = 35; stall_pct = 35; end
    endcase
  endtask

  // list A at capacity plus one dropped push, short list B
  task automatic fill_list_a();
    int i;
    for (i = 0; i <= sst_pkg::MAX_LEN; i++)
      send_item(sst_pkg::KIND_PUSH_A, sst_pkg::WORD_W'(i * 3), 1'b0, NO_SCORE);
    send_item(sst_pkg::KIND_PUSH_B, 32'h0, 1'b0, NO_SCORE);
    send_item(sst_pkg::KIND_PUSH_B, 32'h3, 1'b0, NO_SCORE);
    send_item(sst_pkg::KIND_FINISH, 32'h0, 1'b1, '{17'd128, 11'd2, 12'd1024, 1'b1});
  endtask

  // one random pair of lists, interleaved, then a finish
  task automatic run_pair(input int max_n);
    logic [sst_pkg::WORD_W-1:0] a_q[$];
    logic [sst_pkg::WORD_W-1:0] b_q[$];
    logic [sst_pkg::WORD_W:0]   cur;
    logic [sst_pkg::WORD_W-1:0] mask;
    logic [sst_pkg::WORD_W-1:0] w;
    int                         n;
    int                         i;
    int                         pick;
    n = $urandom_range(max_n, 0);
    if ($urandom_range(99, 0) < 80) begin
      // well-formed: ascending pool, each word to A, B or both
      case ($urandom_range(2, 0))
        0: cur = '0;
        1: cur = {1'b0, $urandom()};
        default: cur = 33'hFFFFFFFF - $urandom_range(200, 0);
      endcase
      mask = 32'hFFFFFFFF >> $urandom_range(31, 0);
      for (i = 0; i < n; i++) begin
        if (cur[sst_pkg::WORD_W]) break;
        pick = $urandom_range(9, 0);
        if (pick < 3 || pick > 5) a_q = {a_q, cur[sst_pkg::WORD_W-1:0]};
        if (pick >= 3) b_q = {b_q, cur[sst_pkg::WORD_W-1:0]};
        cur = cur + 1 + {1'b0, $urandom() & mask};
      end
    end else begin
      // unordered, with repeats
      for (i = 0; i < n; i++) begin
        w = ($urandom_range(3, 0) == 0) ? $urandom()
                                        : sst_pkg::WORD_W'($urandom_range(7, 0));
        if ($urandom_range(1, 0) == 0) a_q = {a_q, w};
        else b_q = {b_q, w};
      end
    end
    while (a_q.size() != 0 || b_q.size() != 0) begin
      if ($urandom_range(99, 0) < 3) send_item(KIND_NONE, $urandom(), 1'b0, NO_SCORE);
      if (b_q.size() == 0 || (a_q.size() != 0 && $urandom_range(1, 0) == 0))
        send_item(sst_pkg::KIND_PUSH_A, a_q.pop_front(), 1'b0, NO_SCORE);
      else
        send_item(sst_pkg::KIND_PUSH_B, b_q.pop_front(), 1'b0, NO_SCORE);
    end
    send_item(sst_pkg::KIND_FINISH, $urandom(), 1'b0, NO_SCORE);
  endtask

  initial begin : main
    int i;
    int base;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = sst_pkg::KIND_PUSH_A;
    in_ch.word    = '0;
    drv_pin       = 1'b0;
    drv_pin_score = NO_SCORE;
    fp_len_a      = 0;
    fp_len_b      = 0;
    fp_dropped    = 1'b0;
    mismatches    = 0;
    sent_items    = 0;
    hold_left     = 0;
    cycles        = 0;
    set_phase(0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 23; i++)
      send_item(DIR_TAB[i].kind, DIR_TAB[i].word, DIR_TAB[i].pinned, DIR_TAB[i].score);

    fill_list_a();

    // long receiver hold-off while finishes keep coming: input side must stall
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 8; i++) run_pair(6);

    base = sent_items;
    while (sent_items - base < RANDOM_ITEMS) begin
      set_phase(((sent_items - base) / PHASE_ITEMS) % 4);
      run_pair(($urandom_range(19, 0) == 0) ? 60 : 12);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("sorted_set_tanimoto_tb OK");
    end else begin
      $display("sorted_set_tanimoto_tb NOT OK");
    end
    $finish;
  end

endmodule

### sorted_set_tanimoto.f
hdl/sst_pkg.sv
hdl/sst_if.sv
hdl/sst_dp.sv
hdl/sst_ctrl.sv
hdl/sorted_set_tanimoto.sv
sim/sorted_set_tanimoto_tb.sv
